### rtl/core/ccbd_pkg.sv
package ccbd_pkg;

    localparam int PIX_W = 8;
    localparam int SUM_W = 32;
    localparam int CNT_W = 25;
    localparam int IDX_W = 8;
    localparam int CFG_W = 14;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_ROW_STRIDE = 2'd2,
        CFG_OUT_SIZE   = 2'd3
    } t_cfg_idx;

    localparam logic [12:0] RST_SRC_WIDTH  = 13'd160;
    localparam logic [12:0] RST_SRC_HEIGHT = 13'd120;
    localparam logic [13:0] RST_ROW_STRIDE = 14'd256;
    localparam logic [6:0]  RST_OUT_SIZE   = 7'd32;

    localparam logic [12:0] ROW_LIMIT = 13'h1FFF;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic [7:0] average;
        logic [5:0] out_x;
        logic [5:0] out_y;
        logic       frame_done;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] pix;
        logic             emit;
    } t_acc_req;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_acc_res;

endpackage

### rtl/core/ccbd_div.sv
module ccbd_div #(
    parameter int DDW = 19,
    parameter int DVW = 13,
    parameter int QW  = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DDW-1:0] i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_done,
    output logic [QW-1:0]  o_quot,
    output logic [DVW-1:0] o_rem
);

    localparam int XW = (DDW > DVW + QW) ? DDW : DVW + QW;
    localparam int CW = $clog2(QW + 1);

    logic [XW-1:0] r_rem;
    logic [XW-1:0] r_dsr;
    logic [QW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic          ge;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= XW'(i_dividend);
            r_dsr  <= XW'(i_divisor) << (QW - 1);
            r_quot <= '0;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_dsr  <= r_dsr >> 1;
            r_quot <= QW'({r_quot, ge});
            r_cnt  <= r_cnt - CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[DVW-1:0];

endmodule

### rtl/core/ccbd_accum.sv
module ccbd_accum #(
    parameter int MAX_OUT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  ccbd_pkg::t_acc_req  i_req,
    output ccbd_pkg::t_acc_res  o_res
);

    localparam int IW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int SW = ccbd_pkg::SUM_W;
    localparam int KW = ccbd_pkg::CNT_W;
    localparam int MW = SW + KW;

    logic [MW-1:0]      r_mem [MAX_OUT];
    logic [MAX_OUT-1:0] r_vld;
    logic [MW-1:0]      r_rd_data;
    logic               r_rd_vld;

    logic               r_act;
    logic [IW-1:0]      r_idx;
    logic [7:0]         r_pix;
    logic               r_emit;

    logic               r_res_valid;
    logic [SW-1:0]      r_res_sum;
    logic [KW-1:0]      r_res_cnt;

    logic [IW-1:0]      rd_idx;
    logic [SW-1:0]      n_sum;
    logic [KW-1:0]      n_cnt;

    assign rd_idx = i_req.idx[IW-1:0];

    always_comb begin
        if (r_rd_vld) begin
            n_sum = r_rd_data[MW-1:KW] + SW'(r_pix);
            n_cnt = r_rd_data[KW-1:0] + KW'(1);
        end else begin
            n_sum = SW'(r_pix);
            n_cnt = KW'(1);
        end
    end

    // bin store: read on request, write back in the cycle after
    always_ff @(posedge i_clk) begin
        if (r_act) begin
            r_mem[r_idx] <= r_emit ? '0 : {n_sum, n_cnt};
        end
        if (i_req.valid) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_act       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_act       <= i_req.valid;
            r_res_valid <= r_act;
            if (i_clear) begin
                r_vld <= '0;
            end else if (r_act) begin
                r_vld[r_idx] <= ~r_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_idx    <= rd_idx;
            r_pix    <= i_req.pix;
            r_emit   <= i_req.emit;
            r_rd_vld <= r_vld[rd_idx];
        end
        if (r_act) begin
            r_res_sum <= n_sum;
            r_res_cnt <= n_cnt;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.sum   = r_res_sum;
    assign o_res.count = r_res_cnt;

endmodule

### rtl/core/center_crop_box_downsample_unit.sv
// Centre-crop box downscaler for a stride-padded luma stream.
// Input channel (i_in_valid/o_in_ready/i_in_data): one luma byte per
// transaction in raster order; frame_start marks the first byte of a frame.
// Output channel (o_out_valid/i_out_ready/o_out_data): one transaction per
// completed bin with its truncated mean, bin coordinates and a flag on the
// last bin of the frame.
// Config port (i_cfg_we/i_cfg_idx/i_cfg_data): width, height, stride and
// output size, to be written only while the block is idle, which the block
// does not enforce itself; o_in_ready is held low in a cycle with a write.
// Rate: one byte at a time; a byte is taken only in the idle state. A dropped
// byte gets the crop test, a kept byte the bin coordinate divide, then one
// read-modify-write of the bin store, and a byte that closes a bin also the
// 8-step mean divide and the output load.
// Reset restores the register defaults (160 x 120, stride 256, size 32),
// clears the raster position and marks every bin empty.
// A stalled receiver holds the output register; the block keeps taking
// bytes until the next completed bin needs that register.
module center_crop_box_downsample_unit #(
    parameter int MAX_OUT = 64,
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ccbd_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ccbd_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  ccbd_pkg::t_cfg_idx            i_cfg_idx,
    input  logic [ccbd_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int NW  = $clog2(MAX_OUT + 1);
    localparam int QW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
    localparam int DDW = DW + NW;
    localparam int LW  = ((DW > NW) ? DW : NW) + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_DIV  = 6'b000100,
        S_ACC  = 6'b001000,
        S_AVG  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [12:0] r_src_width;
    logic [12:0] r_src_height;
    logic [13:0] r_row_stride;
    logic [6:0]  r_out_size;

    logic [13:0] max_dim_v;
    logic [13:0] w_full, h_full, s_full, side_full, n_tmp, n_full;
    logic [13:0] s_eff;

    logic [DW-1:0] r_w, r_h, r_side, r_x0, r_y0;
    logic [NW-1:0] r_n;

    logic [13:0] r_src_col;
    logic [12:0] r_src_row;
    logic [13:0] r_col;
    logic [12:0] r_row;
    logic [7:0]  r_pix;

    logic        in_acc;
    logic [13:0] col_cur;
    logic [12:0] row_cur;

    logic [13:0] col_e, row_e, w_e, h_e, side_e, x0_e, y0_e, px_e, py_e;
    logic        keep;
    logic [DW-1:0]  px1, py1;
    logic [DDW-1:0] prod_x, prod_y;
    logic [DDW-1:0] dd_x, dd_y;

    logic          x_done, y_done, a_done;
    logic [QW-1:0] bx, by;
    logic [DW-1:0] rem_x, rem_y;
    logic [7:0]    avg_q;
    logic          last_x, last_y;
    logic          r_emit, r_fdone;

    ccbd_pkg::t_acc_req acc_req;
    ccbd_pkg::t_acc_res acc_res;

    logic           r_out_valid;
    ccbd_pkg::t_out r_out;
    logic           out_load;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= ccbd_pkg::RST_SRC_WIDTH;
            r_src_height <= ccbd_pkg::RST_SRC_HEIGHT;
            r_row_stride <= ccbd_pkg::RST_ROW_STRIDE;
            r_out_size   <= ccbd_pkg::RST_OUT_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccbd_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[12:0];
                ccbd_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[12:0];
                ccbd_pkg::CFG_ROW_STRIDE: r_row_stride <= i_cfg_data;
                ccbd_pkg::CFG_OUT_SIZE:   r_out_size   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // derived geometry
    always_comb begin
        max_dim_v = 14'(MAX_DIM);
        w_full = ({1'b0, r_src_width} > max_dim_v) ? max_dim_v : {1'b0, r_src_width};
        h_full = ({1'b0, r_src_height} > max_dim_v) ? max_dim_v : {1'b0, r_src_height};
        s_full = (r_row_stride < w_full) ? w_full : r_row_stride;
        s_eff  = (s_full == 14'd0) ? 14'd1 : s_full;
        side_full = (w_full < h_full) ? w_full : h_full;
        n_tmp  = (14'(r_out_size) < side_full) ? 14'(r_out_size) : side_full;
        n_full = (n_tmp < 14'(MAX_OUT)) ? n_tmp : 14'(MAX_OUT);
    end

    always_ff @(posedge i_clk) begin
        r_w    <= DW'(w_full);
        r_h    <= DW'(h_full);
        r_side <= DW'(side_full);
        r_n    <= NW'(n_full);
        r_x0   <= DW'((w_full - side_full) >> 1);
        r_y0   <= DW'((h_full - side_full) >> 1);
    end

    // raster position
    assign o_in_ready = (r_state == S_IDLE) && !i_cfg_we;
    assign in_acc     = i_in_valid && o_in_ready;
    assign col_cur    = i_in_data.frame_start ? 14'd0 : r_src_col;
    assign row_cur    = i_in_data.frame_start ? 13'd0 : r_src_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
        end else if (in_acc) begin
            if (({1'b0, col_cur} + 15'd1) >= {1'b0, s_eff}) begin
                r_src_col <= '0;
                if (row_cur != ccbd_pkg::ROW_LIMIT) begin
                    r_src_row <= row_cur + 13'd1;
                end else begin
                    r_src_row <= row_cur;
                end
            end else begin
                r_src_col <= col_cur + 14'd1;
                r_src_row <= row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_col <= col_cur;
            r_row <= row_cur;
            r_pix <= i_in_data.pixel;
        end
    end

    // crop test and divide operands
    always_comb begin
        col_e  = r_col;
        row_e  = {1'b0, r_row};
        w_e    = 14'(r_w);
        h_e    = 14'(r_h);
        side_e = 14'(r_side);
        x0_e   = 14'(r_x0);
        y0_e   = 14'(r_y0);
        px_e   = col_e - x0_e;
        py_e   = row_e - y0_e;
        keep   = (r_n != '0) && (col_e < w_e) && (row_e < h_e) &&
                 (col_e >= x0_e) && (row_e >= y0_e) &&
                 (px_e < side_e) && (py_e < side_e);
        px1    = DW'(px_e) + DW'(1);
        py1    = DW'(py_e) + DW'(1);
        prod_x = DDW'(px1) * DDW'(r_n);
        prod_y = DDW'(py1) * DDW'(r_n);
        dd_x   = prod_x - DDW'(1);
        dd_y   = prod_y - DDW'(1);
    end

    ccbd_div #(.DDW(DDW), .DVW(DW), .QW(QW)) u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_PREP) && keep),
        .i_dividend (dd_x),
        .i_divisor  (r_side),
        .o_done     (x_done),
        .o_quot     (bx),
        .o_rem      (rem_x)
    );

    ccbd_div #(.DDW(DDW), .DVW(DW), .QW(QW)) u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_PREP) && keep),
        .i_dividend (dd_y),
        .i_divisor  (r_side),
        .o_done     (y_done),
        .o_quot     (by),
        .o_rem      (rem_y)
    );

    // last pixel of a bin when the remainder plus n reaches the side
    assign last_x = (LW'(rem_x) + LW'(r_n)) >= LW'(r_side);
    assign last_y = (LW'(rem_y) + LW'(r_n)) >= LW'(r_side);

    assign acc_req.valid = (r_state == S_DIV) && x_done;
    assign acc_req.idx   = ccbd_pkg::IDX_W'(bx);
    assign acc_req.pix   = r_pix;
    assign acc_req.emit  = last_x && last_y;

    always_ff @(posedge i_clk) begin
        if (acc_req.valid) begin
            r_emit  <= last_x && last_y;
            r_fdone <= (NW'(bx) == r_n - NW'(1)) && (NW'(by) == r_n - NW'(1));
        end
    end

    ccbd_accum #(.MAX_OUT(MAX_OUT)) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (in_acc && i_in_data.frame_start),
        .i_req   (acc_req),
        .o_res   (acc_res)
    );

    ccbd_div #(.DDW(ccbd_pkg::SUM_W), .DVW(ccbd_pkg::CNT_W), .QW(8)) u_div_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_ACC) && acc_res.valid && r_emit),
        .i_dividend (acc_res.sum),
        .i_divisor  (acc_res.count),
        .o_done     (a_done),
        .o_quot     (avg_q),
        .o_rem      ()
    );

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_PREP;
            S_PREP: n_state = keep ? S_DIV : S_IDLE;
            S_DIV:  if (x_done) n_state = S_ACC;
            S_ACC: begin
                if (acc_res.valid) begin
                    n_state = r_emit ? S_AVG : S_IDLE;
                end
            end
            S_AVG:  if (a_done) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.average    <= avg_q;
            r_out.out_x      <= 6'(bx);
            r_out.out_y      <= 6'(by);
            r_out.frame_done <= r_fdone;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_xy_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_done == y_done)
        else $error("coordinate dividers out of step");

    a_acc_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_res.valid |-> (r_state == S_ACC))
        else $error("bin update finished outside accumulate state");

    a_avg_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_done |-> (r_state == S_AVG))
        else $error("mean divide finished outside its state");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done) |-> (o_out_data.out_x == o_out_data.out_y))
        else $error("final bin not on the diagonal");

endmodule

### dv/tb_center_crop_box_downsample_unit.sv
module tb_center_crop_box_downsample_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIN_MAX  = 64;
    localparam int DIM_MAX  = 4096;
    localparam int SETTLE   = 48;
    localparam int HOLD_CYC = 400;
    localparam int RAND_ITEMS = 1820;

    localparam int PIX_RANDOM = 0;
    localparam int PIX_WHITE  = 1;
    localparam int PIX_BLACK  = 2;
    localparam int PIX_NARROW = 3;
    localparam int PIX_TOGGLE = 4;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    ccbd_pkg::t_in              i_in_data = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    ccbd_pkg::t_out             o_out_data;
    logic                       i_cfg_we = 1'b0;
    ccbd_pkg::t_cfg_idx         i_cfg_idx = ccbd_pkg::CFG_SRC_WIDTH;
    logic [ccbd_pkg::CFG_W-1:0] i_cfg_data = '0;

    center_crop_box_downsample_unit #(
        .MAX_OUT(BIN_MAX),
        .MAX_DIM(DIM_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // geometry mirror and bin accumulators
    logic [12:0] geo_width  = ccbd_pkg::RST_SRC_WIDTH;
    logic [12:0] geo_height = ccbd_pkg::RST_SRC_HEIGHT;
    logic [13:0] geo_stride = ccbd_pkg::RST_ROW_STRIDE;
    logic [6:0]  geo_out    = ccbd_pkg::RST_OUT_SIZE;
    logic [31:0] bin_sum [BIN_MAX];
    logic [24:0] bin_cnt [BIN_MAX];
    int unsigned raster_col = 0;
    int unsigned raster_row = 0;

    ccbd_pkg::t_in  luma_queue [$];
    ccbd_pkg::t_out bin_means_due [$];
    ccbd_pkg::t_out bin_head;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          rx_hold = 1'b0;
    bit          in_taken = 1'b0;

    int unsigned n_queued = 0;
    int unsigned n_taken = 0;
    int unsigned n_bins_seen = 0;
    int unsigned n_geo = 0;
    int unsigned n_err = 0;

    initial begin
        for (int k = 0; k < BIN_MAX; k++) begin
            bin_sum[k] = '0;
            bin_cnt[k] = '0;
        end
    end

    task automatic accumulate_luma(input ccbd_pkg::t_in item);
        int unsigned w, h, s, side, x0, y0, n, col, row, px, py, bx, by, avg;
        ccbd_pkg::t_out r;
        if (item.frame_start) begin
            raster_col = 0;
            raster_row = 0;
            for (int k = 0; k < BIN_MAX; k++) begin
                bin_sum[k] = '0;
                bin_cnt[k] = '0;
            end
        end
        w = (geo_width > DIM_MAX) ? DIM_MAX : geo_width;
        h = (geo_height > DIM_MAX) ? DIM_MAX : geo_height;
        s = (geo_stride < w) ? w : geo_stride;
        if (s == 0) s = 1;
        side = (w < h) ? w : h;
        n = (geo_out < side) ? geo_out : side;
        if (n > BIN_MAX) n = BIN_MAX;
        col = raster_col;
        row = raster_row;
        if (col + 1 >= s) begin
            raster_col = 0;
            if (raster_row < ccbd_pkg::ROW_LIMIT) raster_row = raster_row + 1;
        end else begin
            raster_col = col + 1;
        end
        if (n == 0 || col >= w || row >= h) return;
        x0 = (w - side) / 2;
        y0 = (h - side) / 2;
        if (col < x0 || row < y0) return;
        px = col - x0;
        py = row - y0;
        if (px >= side || py >= side) return;
        bx = ((px + 1) * n - 1) / side;
        by = ((py + 1) * n - 1) / side;
        if (bx >= n || by >= n || bx >= BIN_MAX) return;
        bin_sum[bx] = bin_sum[bx] + item.pixel;
        bin_cnt[bx] = bin_cnt[bx] + 1'b1;
        if (px + 1 == ((bx + 1) * side) / n && py + 1 == ((by + 1) * side) / n) begin
            avg = (bin_cnt[bx] != 0) ? bin_sum[bx] / bin_cnt[bx] : 0;
            r.average    = avg[7:0];
            r.out_x      = bx[5:0];
            r.out_y      = by[5:0];
            r.frame_done = (bx == n - 1 && by == n - 1);
            bin_means_due.push_back(r);
            bin_sum[bx] = '0;
            bin_cnt[bx] = '0;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (luma_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= luma_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    initial begin
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_bins_seen++;
                if (bin_means_due.size() == 0) begin
                    $display("%0t: bin with nothing due, actual %p", $time, o_out_data);
                    n_err++;
                end else begin
                    bin_head = bin_means_due.pop_front();
                    if (o_out_data.average !== bin_head.average)
                        $display("%0t: average expected %0d actual %0d", $time,
                                 bin_head.average, o_out_data.average);
                    if (o_out_data.out_x !== bin_head.out_x)
                        $display("%0t: out_x expected %0d actual %0d", $time,
                                 bin_head.out_x, o_out_data.out_x);
                    if (o_out_data.out_y !== bin_head.out_y)
                        $display("%0t: out_y expected %0d actual %0d", $time,
                                 bin_head.out_y, o_out_data.out_y);
                    if (o_out_data.frame_done !== bin_head.frame_done)
                        $display("%0t: frame_done expected %0b actual %0b", $time,
                                 bin_head.frame_done, o_out_data.frame_done);
                    if (o_out_data !== bin_head) n_err++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                accumulate_luma(i_in_data);
                n_taken++;
            end
        end
    end

    task automatic write_reg(input ccbd_pkg::t_cfg_idx idx, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[ccbd_pkg::CFG_W-1:0];
        case (idx)
            ccbd_pkg::CFG_SRC_WIDTH:  geo_width  = value[12:0];
            ccbd_pkg::CFG_SRC_HEIGHT: geo_height = value[12:0];
            ccbd_pkg::CFG_ROW_STRIDE: geo_stride = value[13:0];
            ccbd_pkg::CFG_OUT_SIZE:   geo_out    = value[6:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned s, input int unsigned o);
        write_reg(ccbd_pkg::CFG_SRC_WIDTH, w);
        write_reg(ccbd_pkg::CFG_SRC_HEIGHT, h);
        write_reg(ccbd_pkg::CFG_ROW_STRIDE, s);
        write_reg(ccbd_pkg::CFG_OUT_SIZE, o);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_geo++;
    endtask

    task automatic queue_frame(input int unsigned nbytes, input bit start,
                               input int mode);
        ccbd_pkg::t_in item;
        logic [7:0] base;
        base = 8'($urandom_range(255));
        for (int unsigned k = 0; k < nbytes; k++) begin
            item.frame_start = (k == 0) ? start : ($urandom_range(199) == 0);
            case (mode)
                PIX_WHITE:  item.pixel = 8'hFF;
                PIX_BLACK:  item.pixel = 8'h00;
                PIX_NARROW: item.pixel = base ^ 8'($urandom_range(3));
                PIX_TOGGLE: item.pixel = k[0] ? 8'hFF : 8'h00;
                default:    item.pixel = 8'($urandom_range(255));
            endcase
            luma_queue.push_back(item);
            n_queued++;
        end
    endtask

    // wait for every transaction to be taken and every bin to come back
    task automatic settle();
        do @(negedge i_clk); while (n_taken != n_queued || bin_means_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int unsigned w, h, s, o, side, se, full, nbytes, nfr, r, phase, n_rand;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults straight after reset
        queue_frame(24, 1'b1, PIX_RANDOM);
        settle();
        set_geometry(2, 2, 2, 2);
        queue_frame(4, 1'b1, PIX_TOGGLE);
        settle();
        // zero stride, output size beyond the crop side, bytes past the frame
        set_geometry(3, 2, 0, 127);
        queue_frame(8, 1'b1, PIX_WHITE);
        settle();
        set_geometry(0, 3, 4, 2);
        queue_frame(4, 1'b1, PIX_RANDOM);
        settle();
        set_geometry(3, 3, 3, 0);
        queue_frame(3, 1'b1, PIX_RANDOM);
        settle();
        // frame restarted part way through
        set_geometry(2, 2, 2, 1);
        queue_frame(2, 1'b1, PIX_WHITE);
        queue_frame(4, 1'b1, PIX_NARROW);
        settle();

        // oversized registers, short frames ahead of the crop
        send_idle_pct = 29;
        stall_pct = 29;
        set_geometry(8191, 1, 16383, 127);
        queue_frame(40, 1'b1, PIX_RANDOM);
        settle();
        set_geometry(1, 8191, 1, 64);
        queue_frame(40, 1'b1, PIX_BLACK);
        settle();

        n_rand = 0;
        phase = 0;
        while (n_rand < RAND_ITEMS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            if (phase == 5) begin
                // single-pixel bins with the receiver held off: output backs up
                send_idle_pct = 0;
                stall_pct = 0;
                set_geometry(16, 16, 16, 16);
                hold_go = 1'b1;
                queue_frame(256, 1'b1, PIX_RANDOM);
                n_rand += 256;
                settle();
            end else begin
                r = $urandom_range(15);
                w = (r == 0) ? 0 : ((r == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12));
                r = $urandom_range(15);
                h = (r == 0) ? 0 : ((r == 1) ? $urandom_range(13, 40) : $urandom_range(1, 12));
                case ($urandom_range(3))
                    0, 1: s = w;
                    2:    s = w + $urandom_range(1, 6);
                    default: s = $urandom_range(0, w);
                endcase
                side = (w < h) ? w : h;
                r = $urandom_range(7);
                if (r < 6)
                    o = (side == 0) ? $urandom_range(1, 4) : $urandom_range(1, side);
                else if (r == 6)
                    o = $urandom_range(side + 1, 127);
                else
                    o = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 64 : 127);
                set_geometry(w, h, s, o);
                se = (s < w) ? w : s;
                if (se == 0) se = 1;
                full = se * ((h == 0) ? 3 : h);
                nfr = $urandom_range(1, 3);
                repeat (nfr) begin
                    r = $urandom_range(9);
                    if (r == 0) nbytes = $urandom_range(1, full);
                    else if (r == 1) nbytes = full + $urandom_range(1, 8);
                    else nbytes = full;
                    queue_frame(nbytes, $urandom_range(19) != 0, $urandom_range(3));
                    n_rand += nbytes;
                end
                settle();
            end
            phase++;
        end

        $display("Run covered %0d pixel transactions, %0d output bins, %0d geometries.",
                 n_taken, n_bins_seen, n_geo);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/core/ccbd_pkg.sv
rtl/core/ccbd_div.sv
rtl/core/ccbd_accum.sv
rtl/core/center_crop_box_downsample_unit.sv
dv/tb_center_crop_box_downsample_unit.sv
